>>> src/jts_pkg.sv
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types and constants of the job table scheduler.
// ----------------------------------------------------------------------------
package jts_pkg;

  // Table and time geometry
  localparam int MAX_JOBS = 16;
  localparam int TIME_W   = 16;
  localparam int SLOT_W   = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 3;
  localparam int POL_W    = 3;
  localparam int STAT_W   = 2;

  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_JOBS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_JOBS);

  // Request kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_LOADED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RAN    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IDLE   = 2'd3;

  // Selection policies
  typedef enum logic [POL_W-1:0] {
    POL_SJF  = 3'd0,
    POL_LJF  = 3'd1,
    POL_FCFS = 3'd2,
    POL_SRJF = 3'd3,
    POL_LRJF = 3'd4,
    POL_PRIO = 3'd5
  } pol_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_CALC,
    S_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic scan;
    logic exec;
    logic calc;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic held_hit;
    logic scan_last;
  } stat_t;

endpackage

>>> src/job_table_scheduler.sv
// ----------------------------------------------------------------------------
// job_table_scheduler
// Single-CPU job scheduler over a table of job slots.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request passes
// through accept, a scan of every slot that finds the best ready job and the
// lowest free slot, then execute, time calculation and report. A tick that
// continues a held job under SJF, LJF or FCFS skips the scan. The scan reads
// one table slot per cycle. The result appears for exactly one cycle with
// valid_o high, just as busy drops; the receiver cannot stall it, so it must
// take the result in that cycle. No clearing pass is run after reset; slot
// valid bits reset at once.
module job_table_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [jts_pkg::POL_W-1:0]     cfg_wdata_i,
  input  logic                          command_i,
  input  logic [jts_pkg::ID_W-1:0]      job_id_i,
  input  logic [jts_pkg::TIME_W-1:0]    arrival_time_i,
  input  logic [jts_pkg::TIME_W-1:0]    burst_time_i,
  input  logic [jts_pkg::PRIO_W-1:0]    priority_req_i,
  output logic                          valid_o,
  output logic [jts_pkg::STAT_W-1:0]    status_o,
  output logic [jts_pkg::ID_W-1:0]      run_id_o,
  output logic [jts_pkg::TIME_W-1:0]    now_o,
  output logic                          finished_o,
  output logic [jts_pkg::TIME_W-1:0]    response_time_o,
  output logic [jts_pkg::TIME_W-1:0]    completion_time_o,
  output logic [jts_pkg::TIME_W-1:0]    waiting_time_o,
  output logic [jts_pkg::TIME_W-1:0]    turnaround_time_o,
  output logic [jts_pkg::CNT_W-1:0]     pending_count_o
);
  import jts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the request phases
  jts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Hold the table and compute the result
  jts_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (command_i),
    .job_id_i          (job_id_i),
    .arrival_time_i    (arrival_time_i),
    .burst_time_i      (burst_time_i),
    .priority_req_i    (priority_req_i),
    .valid_o           (valid_o),
    .status_o          (status_o),
    .run_id_o          (run_id_o),
    .now_o             (now_o),
    .finished_o        (finished_o),
    .response_time_o   (response_time_o),
    .completion_time_o (completion_time_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .pending_count_o   (pending_count_o)
  );

endmodule

>>> src/jts_ctrl.sv
// ----------------------------------------------------------------------------
// jts_ctrl
// Sequencer: accept, slot scan, execute, time calculation, report.
// ----------------------------------------------------------------------------
module jts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  jts_pkg::stat_t stat_i,
  output jts_pkg::cmd_t  cmd_o,
  output logic          busy
);
  import jts_pkg::*;

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through the request phases
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.held_hit ? S_EXEC : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> src/jts_datapath.sv
// ----------------------------------------------------------------------------
// jts_datapath
// Job table, best-job tracker, time keeping and result registers.
// ----------------------------------------------------------------------------
module jts_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jts_pkg::cmd_t                 cmd_i,
  output jts_pkg::stat_t                stat_o,
  input  logic                          cfg_we_i,
  input  logic [jts_pkg::POL_W-1:0]     cfg_wdata_i,
  input  logic                          command_i,
  input  logic [jts_pkg::ID_W-1:0]      job_id_i,
  input  logic [jts_pkg::TIME_W-1:0]    arrival_time_i,
  input  logic [jts_pkg::TIME_W-1:0]    burst_time_i,
  input  logic [jts_pkg::PRIO_W-1:0]    priority_req_i,
  output logic                          valid_o,
  output logic [jts_pkg::STAT_W-1:0]    status_o,
  output logic [jts_pkg::ID_W-1:0]      run_id_o,
  output logic [jts_pkg::TIME_W-1:0]    now_o,
  output logic                          finished_o,
  output logic [jts_pkg::TIME_W-1:0]    response_time_o,
  output logic [jts_pkg::TIME_W-1:0]    completion_time_o,
  output logic [jts_pkg::TIME_W-1:0]    waiting_time_o,
  output logic [jts_pkg::TIME_W-1:0]    turnaround_time_o,
  output logic [jts_pkg::CNT_W-1:0]     pending_count_o
);
  import jts_pkg::*;

  // Slot table
  logic [ID_W-1:0]   ident_q   [MAX_JOBS];
  logic [TIME_W-1:0] arr_q     [MAX_JOBS];
  logic [TIME_W-1:0] burst_q   [MAX_JOBS];
  logic [TIME_W-1:0] rem_q     [MAX_JOBS];
  logic [PRIO_W-1:0] prio_q    [MAX_JOBS];
  logic [TIME_W-1:0] first_q   [MAX_JOBS];
  logic [MAX_JOBS-1:0] slot_valid_q, slot_started_q;

  // Control state
  logic [POL_W-1:0]  pol_cfg_q;
  pol_e              pol_q;
  logic              nonpre_q;
  logic [TIME_W-1:0] now_q;
  logic [SLOT_W-1:0] held_slot_q;
  logic              held_valid_q;
  logic [CNT_W-1:0]  count_q;
  logic [SLOT_W-1:0] scan_idx_q;
  logic [SLOT_W-1:0] pick_q, free_q;
  logic              pick_valid_q, free_found_q;

  // Latched request
  logic              cmd_q;
  logic [ID_W-1:0]   id_in_q;
  logic [TIME_W-1:0] arr_in_q, burst_in_q;
  logic [PRIO_W-1:0] prio_in_q;

  // Best candidate keys
  logic [TIME_W-1:0] best_arr_q, best_burst_q, best_rem_q;
  logic [PRIO_W-1:0] best_prio_q;

  // Execute results for the time calculation
  logic [STAT_W-1:0] r_status_q;
  logic [ID_W-1:0]   r_id_q;
  logic              r_fin_q;
  logic [TIME_W-1:0] r_first_q, r_arr_q, r_burst_q, r_comp_q;
  logic [TIME_W-1:0] tat_q, resp_q;

  // Accept-time decisions
  pol_e        pol_in;
  logic        nonpre_in;
  logic        held_hit;

  always_comb begin
    unique case (pol_cfg_q)
      POL_LJF:  pol_in = POL_LJF;
      POL_FCFS: pol_in = POL_FCFS;
      POL_SRJF: pol_in = POL_SRJF;
      POL_LRJF: pol_in = POL_LRJF;
      POL_PRIO: pol_in = POL_PRIO;
      default:  pol_in = POL_SJF;
    endcase
  end

  assign nonpre_in = (pol_in == POL_SJF) || (pol_in == POL_LJF) || (pol_in == POL_FCFS);
  assign held_hit  = (command_i == CMD_TICK) && nonpre_in && held_valid_q &&
                     slot_valid_q[held_slot_q];

  assign stat_o.held_hit  = held_hit;
  assign stat_o.scan_last = (scan_idx_q == SLOT_LAST);

  // Read one slot: the scan index while scanning, else the pick
  logic [SLOT_W-1:0] rd_idx;
  logic [ID_W-1:0]   rd_ident;
  logic [TIME_W-1:0] rd_arr, rd_burst, rd_rem, rd_first;
  logic [PRIO_W-1:0] rd_prio;
  logic              rd_valid, rd_started;

  assign rd_idx     = cmd_i.scan ? scan_idx_q : pick_q;
  assign rd_ident   = ident_q[rd_idx];
  assign rd_arr     = arr_q[rd_idx];
  assign rd_burst   = burst_q[rd_idx];
  assign rd_rem     = rem_q[rd_idx];
  assign rd_prio    = prio_q[rd_idx];
  assign rd_first   = first_q[rd_idx];
  assign rd_valid   = slot_valid_q[rd_idx];
  assign rd_started = slot_started_q[rd_idx];

  // Compare the scanned slot against the best so far
  logic beats;
  always_comb begin
    unique case (pol_q)
      POL_LJF: begin
        beats = (rd_burst != best_burst_q) ? (rd_burst > best_burst_q)
                                           : (rd_prio > best_prio_q);
      end
      POL_FCFS: begin
        beats = (rd_arr != best_arr_q) ? (rd_arr < best_arr_q)
                                       : (rd_prio > best_prio_q);
      end
      POL_SRJF: begin
        beats = (rd_rem != best_rem_q) ? (rd_rem < best_rem_q)
                                       : (rd_prio > best_prio_q);
      end
      POL_LRJF: begin
        beats = (rd_rem != best_rem_q) ? (rd_rem > best_rem_q)
                                       : (rd_prio > best_prio_q);
      end
      POL_PRIO: begin
        beats = (rd_prio != best_prio_q) ? (rd_prio > best_prio_q)
                                         : (rd_rem < best_rem_q);
      end
      default: begin
        beats = (rd_burst != best_burst_q) ? (rd_burst < best_burst_q)
                                           : (rd_prio > best_prio_q);
      end
    endcase
  end

  logic take;
  assign take = rd_valid && (rd_arr <= now_q) && (!pick_valid_q || beats);

  // Execute-phase values
  logic [TIME_W-1:0] time_new, first_new, first_eff, rem_new;
  logic              fin;
  logic              load_ok;

  assign time_new  = (now_q != TIME_MAX) ? now_q + 1'b1 : now_q;
  assign first_new = (now_q != TIME_MAX) ? now_q : TIME_MAX - 1'b1;
  assign first_eff = rd_started ? rd_first : first_new;
  assign rem_new   = (rd_rem != '0) ? rd_rem - 1'b1 : rd_rem;
  assign fin       = (rem_new == '0);
  assign load_ok   = free_found_q && (burst_in_q != '0);

  // Write the slot table
  logic [SLOT_W-1:0] wr_idx;
  assign wr_idx = (cmd_q == CMD_LOAD) ? free_q : pick_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (cmd_q == CMD_LOAD) begin
        if (load_ok) begin
          ident_q[wr_idx] <= id_in_q;
          arr_q[wr_idx]   <= arr_in_q;
          burst_q[wr_idx] <= burst_in_q;
          rem_q[wr_idx]   <= burst_in_q;
          prio_q[wr_idx]  <= prio_in_q;
        end
      end else if (pick_valid_q) begin
        rem_q[wr_idx] <= rem_new;
        if (!rd_started) begin
          first_q[wr_idx] <= first_new;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_cfg_q      <= '0;
      pol_q          <= POL_SJF;
      nonpre_q       <= 1'b0;
      now_q          <= '0;
      held_slot_q    <= '0;
      held_valid_q   <= 1'b0;
      count_q        <= '0;
      scan_idx_q     <= '0;
      pick_q         <= '0;
      free_q         <= '0;
      pick_valid_q   <= 1'b0;
      free_found_q   <= 1'b0;
      slot_valid_q   <= '0;
      slot_started_q <= '0;
      valid_o        <= 1'b0;
    end else begin
      valid_o <= cmd_i.emit;
      if (cfg_we_i) begin
        pol_cfg_q <= cfg_wdata_i;
      end
      // Set up the request
      if (cmd_i.accept) begin
        pol_q        <= pol_in;
        nonpre_q     <= nonpre_in;
        scan_idx_q   <= '0;
        free_found_q <= 1'b0;
        pick_valid_q <= held_hit;
        pick_q       <= held_slot_q;
        if ((command_i == CMD_TICK) && !held_hit) begin
          held_valid_q <= 1'b0;
        end
      end
      // Track the best ready job and the lowest free slot
      if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (take) begin
          pick_q       <= scan_idx_q;
          pick_valid_q <= 1'b1;
        end
        if (!rd_valid && !free_found_q) begin
          free_q       <= scan_idx_q;
          free_found_q <= 1'b1;
        end
      end
      // Apply the load or run one time unit
      if (cmd_i.exec) begin
        if (cmd_q == CMD_LOAD) begin
          if (load_ok) begin
            slot_valid_q[wr_idx]   <= 1'b1;
            slot_started_q[wr_idx] <= 1'b0;
            count_q                <= count_q + 1'b1;
          end
        end else begin
          now_q <= time_new;
          if (pick_valid_q) begin
            if (fin) begin
              slot_valid_q[wr_idx]   <= 1'b0;
              slot_started_q[wr_idx] <= 1'b0;
              held_valid_q           <= 1'b0;
              if (count_q != '0) begin
                count_q <= count_q - 1'b1;
              end
            end else begin
              slot_started_q[wr_idx] <= 1'b1;
              if (nonpre_q) begin
                held_slot_q  <= pick_q;
                held_valid_q <= 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q      <= command_i;
      id_in_q    <= job_id_i;
      arr_in_q   <= arrival_time_i;
      burst_in_q <= burst_time_i;
      prio_in_q  <= priority_req_i;
    end
    if (cmd_i.scan && take) begin
      best_arr_q   <= rd_arr;
      best_burst_q <= rd_burst;
      best_rem_q   <= rd_rem;
      best_prio_q  <= rd_prio;
    end
    // Capture what the report needs
    if (cmd_i.exec) begin
      r_first_q <= first_eff;
      r_arr_q   <= rd_arr;
      r_burst_q <= rd_burst;
      r_comp_q  <= time_new;
      if (cmd_q == CMD_LOAD) begin
        r_status_q <= load_ok ? STAT_LOADED : STAT_REJECT;
        r_id_q     <= '0;
        r_fin_q    <= 1'b0;
      end else if (pick_valid_q) begin
        r_status_q <= STAT_RAN;
        r_id_q     <= rd_ident;
        r_fin_q    <= fin;
      end else begin
        r_status_q <= STAT_IDLE;
        r_id_q     <= '0;
        r_fin_q    <= 1'b0;
      end
    end
    if (cmd_i.calc) begin
      tat_q  <= r_comp_q - r_arr_q;
      resp_q <= r_first_q - r_arr_q;
    end
    // Drive the result
    if (cmd_i.emit) begin
      status_o          <= r_status_q;
      run_id_o          <= r_id_q;
      now_o             <= now_q;
      finished_o        <= r_fin_q;
      pending_count_o   <= count_q;
      response_time_o   <= r_fin_q ? resp_q : '0;
      completion_time_o <= r_fin_q ? r_comp_q : '0;
      turnaround_time_o <= r_fin_q ? tat_q : '0;
      waiting_time_o    <= (r_fin_q && (tat_q >= r_burst_q)) ? tat_q - r_burst_q : '0;
    end
  end

endmodule

>>> src/jts_checker.sv
// ----------------------------------------------------------------------------
// jts_checker
// Port-level checks of the job table scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module jts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          valid_o,
  input logic [jts_pkg::STAT_W-1:0]    status_o,
  input logic                          finished_o,
  input logic [jts_pkg::TIME_W-1:0]    response_time_o,
  input logic [jts_pkg::TIME_W-1:0]    turnaround_time_o,
  input logic [jts_pkg::CNT_W-1:0]     pending_count_o
);
  import jts_pkg::*;

  // An accepted request keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  // A result shows up only once the block is free again
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  // The result strobe lasts a single cycle
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // Only a job that ran can finish, and a finish leaves the table below full
  a_finish_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && finished_o |-> (status_o == STAT_RAN) && (pending_count_o < CNT_FULL))
    else $error("finish without a run or pending count overflow");

  // Response and turnaround times are zero unless a job finished
  a_times_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !finished_o |-> (response_time_o == '0) && (turnaround_time_o == '0))
    else $error("time fields set without a finished job");

endmodule

bind job_table_scheduler jts_checker u_jts_checker (.*);

>>> test/job_table_scheduler_tb.sv
// ----------------------------------------------------------------------------
// job_table_scheduler_tb
// Self-checking bench for the job table scheduler. A behavioral copy of the
// job table, the time counter and the selection rules predicts the result of
// every accepted request. A monitor checks each result strobe field by field
// against the oldest prediction. Directed cases cover rejects, idle ticks,
// tie breaks, held jobs and a final drain under priority preemption. Random
// batches of loads and ticks then run under every policy code.
// ----------------------------------------------------------------------------
module job_table_scheduler_tb;
  import jts_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int SHOW_LIMIT   = 100;
  localparam int DRAIN_CYCLES = 2 * (MAX_JOBS + 4);
  localparam int MAX_GAP      = 40;

  // Clock, reset and block ports
  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                start             = 1'b0;
  logic                busy;
  logic                cfg_we_i          = 1'b0;
  logic [POL_W-1:0]    cfg_wdata_i       = '0;
  logic                command_i         = CMD_LOAD;
  logic [ID_W-1:0]     job_id_i          = '0;
  logic [TIME_W-1:0]   arrival_time_i    = '0;
  logic [TIME_W-1:0]   burst_time_i      = '0;
  logic [PRIO_W-1:0]   priority_req_i    = '0;
  logic                valid_o;
  logic [STAT_W-1:0]   status_o;
  logic [ID_W-1:0]     run_id_o;
  logic [TIME_W-1:0]   now_o;
  logic                finished_o;
  logic [TIME_W-1:0]   response_time_o;
  logic [TIME_W-1:0]   completion_time_o;
  logic [TIME_W-1:0]   waiting_time_o;
  logic [TIME_W-1:0]   turnaround_time_o;
  logic [CNT_W-1:0]    pending_count_o;

  // One result as the block reports it
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   run_id;
    logic [TIME_W-1:0] now;
    logic              finished;
    logic [TIME_W-1:0] response;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] turnaround;
    logic [CNT_W-1:0]  pending;
  } sched_result_t;

  sched_result_t due_results[$];
  sched_result_t head_result;

  // Shadow job table and scheduler state
  logic [ID_W-1:0]   tbl_id        [MAX_JOBS];
  logic [TIME_W-1:0] tbl_arrival   [MAX_JOBS];
  logic [TIME_W-1:0] tbl_burst     [MAX_JOBS];
  logic [TIME_W-1:0] tbl_left      [MAX_JOBS];
  logic [TIME_W-1:0] tbl_first_run [MAX_JOBS];
  logic [PRIO_W-1:0] tbl_prio      [MAX_JOBS];
  bit                tbl_valid     [MAX_JOBS];
  bit                tbl_started   [MAX_JOBS];
  logic [TIME_W-1:0] clock_now  = '0;
  int                held_idx   = 0;
  bit                held_on    = 1'b0;
  int                job_count  = 0;
  logic [POL_W-1:0]  policy_reg = POL_SJF;

  // Run statistics
  int idle_pct    = 0;
  int mismatches  = 0;
  int n_requests  = 0;
  int n_loaded    = 0;
  int n_rejected  = 0;
  int n_ran       = 0;
  int n_idle      = 0;
  int n_completed = 0;

  job_table_scheduler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (command_i),
    .job_id_i          (job_id_i),
    .arrival_time_i    (arrival_time_i),
    .burst_time_i      (burst_time_i),
    .priority_req_i    (priority_req_i),
    .valid_o           (valid_o),
    .status_o          (status_o),
    .run_id_o          (run_id_o),
    .now_o             (now_o),
    .finished_o        (finished_o),
    .response_time_o   (response_time_o),
    .completion_time_o (completion_time_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .pending_count_o   (pending_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Decide whether slot a strictly wins over slot b under the given policy
  function automatic bit outranks(pol_e pol, int a, int b);
    logic [TIME_W-1:0] ka;
    logic [TIME_W-1:0] kb;
    bit                smaller_wins;
    if (pol == POL_PRIO) begin
      if (tbl_prio[a] != tbl_prio[b]) return tbl_prio[a] > tbl_prio[b];
      return tbl_left[a] < tbl_left[b];
    end
    case (pol)
      POL_LJF: begin
        ka = tbl_burst[a]; kb = tbl_burst[b]; smaller_wins = 1'b0;
      end
      POL_FCFS: begin
        ka = tbl_arrival[a]; kb = tbl_arrival[b]; smaller_wins = 1'b1;
      end
      POL_SRJF: begin
        ka = tbl_left[a]; kb = tbl_left[b]; smaller_wins = 1'b1;
      end
      POL_LRJF: begin
        ka = tbl_left[a]; kb = tbl_left[b]; smaller_wins = 1'b0;
      end
      default: begin
        ka = tbl_burst[a]; kb = tbl_burst[b]; smaller_wins = 1'b1;
      end
    endcase
    if (ka != kb) return smaller_wins ? (ka < kb) : (ka > kb);
    return tbl_prio[a] > tbl_prio[b];
  endfunction

  // Apply one request to the shadow table and return the result it must give
  function automatic sched_result_t schedule_step(logic cmd, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] arr, logic [TIME_W-1:0] len, logic [PRIO_W-1:0] prio);
    sched_result_t r;
    pol_e          pol;
    bit            keep_job;
    int            pick;
    int            slot;
    r = '0;
    if (cmd == CMD_LOAD) begin
      // Take the lowest free slot
      slot = MAX_JOBS;
      for (int i = MAX_JOBS - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
      if (slot == MAX_JOBS || len == '0) begin
        r.status = STAT_REJECT;
      end else begin
        tbl_id[slot]        = id;
        tbl_arrival[slot]   = arr;
        tbl_burst[slot]     = len;
        tbl_left[slot]      = len;
        tbl_prio[slot]      = prio;
        tbl_first_run[slot] = '0;
        tbl_valid[slot]     = 1'b1;
        tbl_started[slot]   = 1'b0;
        job_count++;
        r.status = STAT_LOADED;
      end
    end else begin
      // Unused codes fall back to shortest job first
      pol      = (policy_reg > POL_PRIO) ? POL_SJF : pol_e'(policy_reg);
      keep_job = (pol == POL_SJF || pol == POL_LJF || pol == POL_FCFS);
      pick     = MAX_JOBS;
      if (keep_job && held_on && tbl_valid[held_idx]) begin
        pick = held_idx;
      end else begin
        held_on = 1'b0;
        for (int i = 0; i < MAX_JOBS; i++) begin
          if (tbl_valid[i] && tbl_arrival[i] <= clock_now &&
              (pick == MAX_JOBS || outranks(pol, i, pick))) pick = i;
        end
      end
      if (clock_now != TIME_MAX) clock_now++;
      if (pick == MAX_JOBS) begin
        r.status = STAT_IDLE;
      end else begin
        r.status = STAT_RAN;
        r.run_id = tbl_id[pick];
        if (!tbl_started[pick]) begin
          tbl_started[pick]   = 1'b1;
          tbl_first_run[pick] = clock_now - 1'b1;
        end
        if (keep_job) begin
          held_idx = pick;
          held_on  = 1'b1;
        end
        if (tbl_left[pick] != '0) tbl_left[pick]--;
        if (tbl_left[pick] == '0) begin
          r.finished   = 1'b1;
          r.completion = clock_now;
          r.response   = tbl_first_run[pick] - tbl_arrival[pick];
          r.turnaround = clock_now - tbl_arrival[pick];
          r.waiting    = (r.turnaround >= tbl_burst[pick]) ?
                         r.turnaround - tbl_burst[pick] : '0;
          tbl_valid[pick]   = 1'b0;
          tbl_started[pick] = 1'b0;
          if (job_count > 0) job_count--;
          held_on = 1'b0;
        end
      end
    end
    r.now     = clock_now;
    r.pending = CNT_W'(job_count);
    return r;
  endfunction

  // Count unfinished jobs, optionally leaving out those parked at the last time unit
  function automatic int jobs_left(bit with_parked);
    int n;
    n = 0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      if (tbl_valid[i] && (with_parked || tbl_arrival[i] != TIME_MAX)) n++;
    end
    return n;
  endfunction

  // Send one request after a random gap and record its predicted result
  task automatic send_request(logic cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
      logic [TIME_W-1:0] len, logic [PRIO_W-1:0] prio);
    sched_result_t due;
    int            gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= cmd;
    job_id_i       <= id;
    arrival_time_i <= arr;
    burst_time_i   <= len;
    priority_req_i <= prio;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    due = schedule_step(cmd, id, arr, len, prio);
    due_results.insert(due_results.size(), due);
    n_requests++;
    case (due.status)
      STAT_LOADED: n_loaded++;
      STAT_REJECT: n_rejected++;
      STAT_RAN:    n_ran++;
      default:     n_idle++;
    endcase
    if (due.finished) n_completed++;
  endtask

  // Advance time by one unit; the payload fields carry noise
  task automatic send_tick();
    send_request(CMD_TICK, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                 PRIO_W'($urandom));
  endtask

  // Change the policy once every outstanding result has come back
  task automatic write_policy(logic [POL_W-1:0] value);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    policy_reg = value;
  endtask

  task automatic tick_until_clear(bit with_parked);
    while (jobs_left(with_parked) != 0) send_tick();
  endtask

  // Mostly well-formed loads near the current time; noise that must be rejected
  task automatic send_random_load();
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] len;
    int                roll;
    roll = $urandom_range(99);
    if (job_count == MAX_JOBS || roll < 8) begin
      arr = TIME_W'($urandom);
      len = (job_count == MAX_JOBS) ? TIME_W'($urandom) : '0;
    end else begin
      arr = (roll < 30 && clock_now > 16'd8) ? clock_now - TIME_W'($urandom_range(8))
                                             : clock_now + TIME_W'($urandom_range(6));
      len = (roll < 80) ? TIME_W'($urandom_range(1, 8)) : TIME_W'($urandom_range(9, 40));
    end
    send_request(CMD_LOAD, ID_W'($urandom), arr, len, PRIO_W'($urandom));
  endtask

  // Zero burst, tick on an empty table, and a job parked at the last time unit
  task automatic test_reject_and_idle();
    send_request(CMD_LOAD, 8'hFF, TIME_MAX, '0, 3'd7);
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_LOAD, 8'hFF, TIME_MAX, 16'd1, 3'd7);
  endtask

  // Equal bursts: higher priority first, then the lower slot
  task automatic test_tie_rules();
    send_request(CMD_LOAD, 8'h00, 16'h0000, 16'd3, 3'd0);
    send_request(CMD_LOAD, 8'h01, 16'h0000, 16'd3, 3'd5);
    send_request(CMD_LOAD, 8'h02, 16'h0000, 16'd3, 3'd5);
    send_request(CMD_LOAD, 8'h03, clock_now + 16'd2, 16'd1, 3'd0);
    tick_until_clear(1'b0);
  endtask

  // Hold a started job under FCFS, then drop the hold under priority
  task automatic test_held_job();
    write_policy(POL_FCFS);
    send_request(CMD_LOAD, 8'h10, clock_now, 16'd4, 3'd1);
    send_tick();
    send_request(CMD_LOAD, 8'h11, 16'h0000, 16'd1, 3'd6);
    send_tick();
    write_policy(POL_PRIO);
    send_tick();
    send_tick();
    write_policy(POL_SJF);
    tick_until_clear(1'b0);
  endtask

  // Random batches of loads and ticks under every policy code
  task automatic test_random_traffic();
    int first;
    int done;
    int batch;
    int loads;
    first = n_requests;
    batch = 0;
    while (n_requests - first < RANDOM_ITEMS) begin
      done     = n_requests - first;
      idle_pct = (done < RANDOM_ITEMS / 3) ? 36 : (done < 2 * RANDOM_ITEMS / 3) ? 58 : 0;
      // Walk all eight codes in order first, then pick at random
      if (batch % 3 == 0) begin
        write_policy((batch / 3 < 8) ? POL_W'(batch / 3) : POL_W'($urandom_range(7)));
      end
      loads = ($urandom_range(99) < 15) ? $urandom_range(10, 17) : $urandom_range(1, 5);
      repeat (loads) begin
        if ($urandom_range(99) < 25) send_tick();
        send_random_load();
      end
      if ($urandom_range(99) < 35) tick_until_clear(1'b0);
      else repeat ($urandom_range(1, 24)) send_tick();
      batch++;
    end
  endtask

  // Finish what is left, then let an urgent job preempt a longer one
  task automatic test_final_drain();
    idle_pct = 0;
    tick_until_clear(1'b0);
    write_policy(POL_PRIO);
    send_request(CMD_LOAD, 8'h3C, clock_now, 16'd6, 3'd2);
    send_request(CMD_LOAD, 8'h3D, clock_now + 16'd2, 16'd2, 3'd7);
    tick_until_clear(1'b0);
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    end
  endtask

  // Check every result strobe against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding, expected none, actual status %0d",
                 $time, status_o);
      end else begin
        head_result = due_results.pop_front();
        check_field("status", 32'(head_result.status), 32'(status_o));
        check_field("run_id", 32'(head_result.run_id), 32'(run_id_o));
        check_field("now", 32'(head_result.now), 32'(now_o));
        check_field("finished", 32'(head_result.finished), 32'(finished_o));
        check_field("response_time", 32'(head_result.response), 32'(response_time_o));
        check_field("completion_time", 32'(head_result.completion),
                    32'(completion_time_o));
        check_field("waiting_time", 32'(head_result.waiting), 32'(waiting_time_o));
        check_field("turnaround_time", 32'(head_result.turnaround),
                    32'(turnaround_time_o));
        check_field("pending_count", 32'(head_result.pending), 32'(pending_count_o));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reject_and_idle();
    test_tie_rules();
    test_held_job();
    test_random_traffic();
    test_final_drain();
    // Drain outstanding results, then let the block settle
    start <= 1'b0;
    for (int k = 0; k < 100 * DRAIN_CYCLES && due_results.size() != 0; k++) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) begin
      mismatches += due_results.size();
      $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, due_results.size(), due_results.size());
    end
    $display("Ran %0d requests: %0d loads, %0d rejected, %0d ticks run, %0d idle ticks",
             n_requests, n_loaded, n_rejected, n_ran, n_idle);
    $display("%0d jobs completed under all eight policy codes; final time %0d",
             n_completed, clock_now);
    if (mismatches == 0) begin
      $display("job_table_scheduler_tb OK");
    end else begin
      $display("job_table_scheduler_tb NOT OK");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule
  initial begin
    #64000000;
    $display("job_table_scheduler_tb NOT OK");
    $finish;
  end

endmodule
